/* hdl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// shared constants, codes and types of the stack machine executor
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int STEP_W      = $clog2(DATA_W);

  typedef logic [3:0]        opcode_t;
  typedef logic [2:0]        status_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam opcode_t OP_PUSH     = 4'd0;
  localparam opcode_t OP_PRINTALL = 4'd1;
  localparam opcode_t OP_PRINTTOP = 4'd2;
  localparam opcode_t OP_POP      = 4'd3;
  localparam opcode_t OP_SWAP     = 4'd4;
  localparam opcode_t OP_ADD      = 4'd5;
  localparam opcode_t OP_NOP      = 4'd6;
  localparam opcode_t OP_DIV      = 4'd7;
  localparam opcode_t OP_MUL      = 4'd8;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_EMPTY   = 3'd1;
  localparam status_t ST_SHORT   = 3'd2;
  localparam status_t ST_DIVZERO = 3'd3;
  localparam status_t ST_FULL    = 3'd4;
  localparam status_t ST_HALTED  = 3'd5;

endpackage

/* hdl/smx_div.sv */
// ----------------------------------------------------------------------------
// smx_div
// iterative signed 32-bit divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module smx_div
  import smx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] dividend,
  input  logic signed [DATA_W-1:0] divisor,
  output logic                     done,
  output logic signed [DATA_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  word_t             rem;
  word_t             quo;
  word_t             mag_b;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted  = {rem, quo[DATA_W-1]};
  assign diff     = shifted - {1'b0, mag_b};
  // INT_MIN / -1 comes out as INT_MIN since the magnitude wraps back
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      mag_b <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem   <= '0;
      cnt   <= STEP_W'(DATA_W - 1);
    end else if (busy) begin
      cnt <= cnt - STEP_W'(1);
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* hdl/stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// executes one stack instruction per item on a 64-entry stack of 32-bit words
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_ready is high only while the unit is
// idle. The stack sits in a single-port-write, single-port-read memory with a
// registered read, so timing is set by memory reads. Push, pop, nop, halted
// items and the empty, too-short and full errors go straight to the result;
// printtop first reads the top entry; add, swap, mul and div first read the
// top entry and then the one below it; div with a nonzero divisor then waits
// on a divider that yields one quotient bit per cycle. Print-all reads one
// entry per result. Each result waits in the output register for out_ready;
// a result held there stalls the next one. No clearing pass after reset.
module stack_machine_executor_unit
  import smx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0]               mode,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] data,
  output logic                     data_valid,
  output logic                     last
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EMIT    = 4'd1;
  localparam logic [3:0] S_PT_WAIT = 4'd2;
  localparam logic [3:0] S_PA_RD   = 4'd3;
  localparam logic [3:0] S_PA_WAIT = 4'd4;
  localparam logic [3:0] S_PA_OUT  = 4'd5;
  localparam logic [3:0] S_B_TOP   = 4'd6;
  localparam logic [3:0] S_B_BELOW = 4'd7;
  localparam logic [3:0] S_B_EXEC  = 4'd8;
  localparam logic [3:0] S_SWAP2   = 4'd9;
  localparam logic [3:0] S_MUL     = 4'd10;
  localparam logic [3:0] S_DIV     = 4'd11;

  word_t             mem [STACK_DEPTH];
  word_t             rdata;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  word_t             wr_data;

  logic [3:0]        state;
  logic [CNT_W-1:0]  count;
  logic              halted;
  opcode_t           op;
  logic [PTR_W-1:0]  idx;
  word_t             opa;
  word_t             opb;
  word_t             alu_res;
  status_t           res_status;
  word_t             res_data;
  logic              res_dv;

  logic              accept;
  logic              slot_free;
  logic              load_out;
  logic              is_bin;
  logic              full;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic              div_start;
  logic              div_done;
  logic signed [DATA_W-1:0] div_q;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign load_out  = ((state == S_EMIT) || (state == S_PA_OUT)) && slot_free;
  assign is_bin    = (mode == OP_SWAP) || (mode == OP_ADD) || (mode == OP_DIV) ||
                     (mode == OP_MUL);
  assign full      = (count >= CNT_W'(STACK_DEPTH));
  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign div_start = (state == S_B_EXEC) && (op == OP_DIV) && (opa != '0);

  smx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opb),
    .divisor  (opa),
    .done     (div_done),
    .quotient (div_q)
  );

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_m1[PTR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = cnt_m2[PTR_W-1:0];
    wr_data = opb;
    unique case (state)
      S_IDLE: begin
        if (accept && !halted) begin
          if (mode == OP_PUSH && !full) begin
            wr_en   = 1'b1;
            wr_addr = count[PTR_W-1:0];
            wr_data = push_value;
          end
          if ((mode == OP_PRINTTOP && count != '0) ||
              (is_bin && count >= CNT_W'(2))) begin
            rd_en = 1'b1;
          end
        end
      end
      S_PA_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      S_B_TOP: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m2[PTR_W-1:0];
      end
      S_B_EXEC: begin
        if (op == OP_SWAP) begin
          wr_en   = 1'b1;
          wr_addr = cnt_m1[PTR_W-1:0];
          wr_data = opb;
        end else if (op == OP_ADD) begin
          wr_en   = 1'b1;
          wr_data = opb + opa;
        end
      end
      S_SWAP2: begin
        wr_en   = 1'b1;
        wr_data = opa;
      end
      S_MUL: begin
        wr_en   = 1'b1;
        wr_data = alu_res;
      end
      S_DIV: begin
        wr_en   = div_done;
        wr_data = div_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // sequencer and stack bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= mode;
            res_data <= '0;
            res_dv   <= 1'b0;
            if (halted) begin
              res_status <= ST_HALTED;
              state      <= S_EMIT;
            end else begin
              unique case (1'b1)
                mode == OP_PUSH: begin
                  state <= S_EMIT;
                  if (full) begin
                    res_status <= ST_FULL;
                    halted     <= 1'b1;
                  end else begin
                    res_status <= ST_OK;
                    count      <= count + CNT_W'(1);
                  end
                end
                mode == OP_POP || mode == OP_PRINTTOP: begin
                  if (count == '0) begin
                    res_status <= ST_EMPTY;
                    halted     <= 1'b1;
                    state      <= S_EMIT;
                  end else if (mode == OP_POP) begin
                    res_status <= ST_OK;
                    count      <= cnt_m1;
                    state      <= S_EMIT;
                  end else begin
                    res_status <= ST_OK;
                    state      <= S_PT_WAIT;
                  end
                end
                mode == OP_PRINTALL: begin
                  res_status <= ST_OK;
                  if (count != '0) begin
                    idx   <= cnt_m1[PTR_W-1:0];
                    state <= S_PA_RD;
                  end else begin
                    state <= S_EMIT;
                  end
                end
                is_bin: begin
                  if (count < CNT_W'(2)) begin
                    res_status <= ST_SHORT;
                    halted     <= 1'b1;
                    state      <= S_EMIT;
                  end else begin
                    res_status <= ST_OK;
                    state      <= S_B_TOP;
                  end
                end
                default: begin
                  res_status <= ST_OK;
                  state      <= S_EMIT;
                end
              endcase
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            status     <= res_status;
            data       <= res_data;
            data_valid <= res_dv;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_PT_WAIT: begin
          res_data <= rdata;
          res_dv   <= 1'b1;
          state    <= S_EMIT;
        end
        S_PA_RD: begin
          state <= S_PA_WAIT;
        end
        S_PA_WAIT: begin
          opa   <= rdata;
          state <= S_PA_OUT;
        end
        S_PA_OUT: begin
          if (slot_free) begin
            status     <= ST_OK;
            data       <= opa;
            data_valid <= 1'b1;
            last       <= (idx == '0);
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - PTR_W'(1);
              state <= S_PA_RD;
            end
          end
        end
        S_B_TOP: begin
          opa   <= rdata;
          state <= S_B_BELOW;
        end
        S_B_BELOW: begin
          opb   <= rdata;
          state <= S_B_EXEC;
        end
        S_B_EXEC: begin
          unique case (1'b1)
            op == OP_SWAP: state <= S_SWAP2;
            op == OP_ADD: begin
              count <= cnt_m1;
              state <= S_EMIT;
            end
            op == OP_MUL: begin
              alu_res <= opb * opa;
              state   <= S_MUL;
            end
            default: begin
              // divide
              if (opa == '0) begin
                res_status <= ST_DIVZERO;
                halted     <= 1'b1;
                state      <= S_EMIT;
              end else begin
                state <= S_DIV;
              end
            end
          endcase
        end
        S_SWAP2: begin
          state <= S_EMIT;
        end
        S_MUL: begin
          count <= cnt_m1;
          state <= S_EMIT;
        end
        S_DIV: begin
          if (div_done) begin
            count <= cnt_m1;
            state <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/smx_checker.sv */
// ----------------------------------------------------------------------------
// smx_checker
// port-level checks on the result channel of the stack machine executor
// ----------------------------------------------------------------------------
module smx_checker
  import smx_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [2:0]               status,
  input logic signed [DATA_W-1:0] data,
  input logic                     data_valid,
  input logic                     last
);

  logic seen_err;

  // sticky once an error result has been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_err <= 1'b0;
    end else if (out_valid && out_ready &&
                 (status == ST_EMPTY || status == ST_SHORT ||
                  status == ST_DIVZERO || status == ST_FULL)) begin
      seen_err <= 1'b1;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_err |-> status == ST_HALTED)
    else $error("result after an error is not reported as halted");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !data_valid && last)
    else $error("error or halted result carries data or is not last");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data == '0)
    else $error("data not zero on a result without data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status) &&
                                $stable(last))
    else $error("stalled result changed");

endmodule

bind stack_machine_executor_unit smx_checker u_smx_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .data       (data),
  .data_valid (data_valid),
  .last       (last)
);

/* verif/tb_stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// tb_stack_machine_executor_unit
// self-checking bench for the stack machine executor: a planned instruction
// stream is offered over valid/ready, a shadow stack predicts every result,
// and the monitor compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module tb_stack_machine_executor_unit;
  import smx_pkg::*;

  localparam int      HALF_PERIOD    = 6;
  localparam int      RESET_CYCLES   = 5;
  localparam int      RANDOM_ITEMS   = 230;
  localparam int      TAIL_ITEMS     = 30;
  localparam int      HOLD_AFTER     = 100;
  localparam int      HOLD_CYCLES    = 400;
  localparam int      DRAIN_CYCLES   = 250;
  localparam int      TIMEOUT_CYCLES = 5_000_000;
  localparam opcode_t OP_FIRST_SPARE = 4'd9;
  localparam opcode_t OP_LAST_SPARE  = 4'hF;
  localparam word_t   WORD_MAX       = 32'h7FFF_FFFF;
  localparam word_t   WORD_MIN       = 32'h8000_0000;
  localparam word_t   WORD_ONE       = 32'h0000_0001;
  localparam word_t   WORD_MINUS_ONE = 32'hFFFF_FFFF;

  typedef struct {
    opcode_t op;
    word_t   arg;
  } instr_t;

  typedef struct {
    status_t status;
    word_t   data;
    logic    data_valid;
    logic    last;
  } print_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [3:0]               mode = OP_NOP;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     data_valid;
  logic                     last;

  instr_t        pending_instrs[$];
  print_result_t expected_results[$];

  // shadow copy of the executor state
  word_t shadow_stack[STACK_DEPTH];
  int    shadow_depth = 0;
  bit    shadow_halted = 1'b0;

  int plan_depth = 0;
  int total_items = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int window_left = 0;
  bit idle_on = 1'b0;
  bit idle_ok;

  stack_machine_executor_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data       (data),
    .data_valid (data_valid),
    .last       (last)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic word_t quotient_toward_zero(word_t num, word_t den);
    word_t mag_n;
    word_t mag_d;
    word_t q;
    mag_n = num[DATA_W-1] ? word_t'(-num) : num;
    mag_d = den[DATA_W-1] ? word_t'(-den) : den;
    q = mag_n / mag_d;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? word_t'(-q) : q;
  endfunction

  function automatic void expect_result(status_t st, word_t value, logic dv, logic lst);
    print_result_t r;
    r.status     = st;
    r.data       = value;
    r.data_valid = dv;
    r.last       = lst;
    expected_results.push_back(r);
  endfunction

  task automatic execute_instr(opcode_t op, word_t arg);
    status_t st;
    word_t   top_w;
    word_t   below_w;
    st = ST_OK;
    if (shadow_halted) begin
      expect_result(ST_HALTED, '0, 1'b0, 1'b1);
      return;
    end
    case (op)
      OP_PUSH: begin
        if (shadow_depth == STACK_DEPTH) begin
          st = ST_FULL;
        end else begin
          shadow_stack[shadow_depth] = arg;
          shadow_depth++;
        end
      end
      OP_PRINTALL: begin
        if (shadow_depth == 0) begin
          expect_result(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          for (int i = shadow_depth - 1; i >= 0; i--)
            expect_result(ST_OK, shadow_stack[i], 1'b1, i == 0);
        end
        return;
      end
      OP_PRINTTOP: begin
        if (shadow_depth == 0) begin
          st = ST_EMPTY;
        end else begin
          expect_result(ST_OK, shadow_stack[shadow_depth-1], 1'b1, 1'b1);
          return;
        end
      end
      OP_POP: begin
        if (shadow_depth == 0) st = ST_EMPTY;
        else shadow_depth--;
      end
      OP_SWAP, OP_ADD, OP_DIV, OP_MUL: begin
        if (shadow_depth < 2) begin
          st = ST_SHORT;
        end else begin
          top_w   = shadow_stack[shadow_depth-1];
          below_w = shadow_stack[shadow_depth-2];
          if (op == OP_SWAP) begin
            shadow_stack[shadow_depth-1] = below_w;
            shadow_stack[shadow_depth-2] = top_w;
          end else if (op == OP_DIV && top_w == '0) begin
            st = ST_DIVZERO;
          end else begin
            case (op)
              OP_ADD:  shadow_stack[shadow_depth-2] = below_w + top_w;
              OP_MUL:  shadow_stack[shadow_depth-2] = below_w * top_w;
              default: shadow_stack[shadow_depth-2] = quotient_toward_zero(below_w, top_w);
            endcase
            shadow_depth--;
          end
        end
      end
      default: ;
    endcase
    if (st != ST_OK) shadow_halted = 1'b1;
    expect_result(st, '0, 1'b0, 1'b1);
  endtask

  // ------------------------------------------------------------------ planning

  function automatic word_t rand_word();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_MINUS_ONE;
      3: return word_t'($urandom_range(0, 1));
      4, 5: return word_t'($urandom_range(0, 200)) - word_t'(100);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t nonzero_word();
    word_t w;
    w = rand_word();
    while (w == '0) w = rand_word();
    return w;
  endfunction

  // plan_depth follows the stack depth assuming the stream stays error free
  function automatic void queue_instr(opcode_t op, word_t arg);
    instr_t it;
    it.op  = op;
    it.arg = arg;
    pending_instrs.push_back(it);
    case (op)
      OP_PUSH: plan_depth++;
      OP_POP, OP_ADD, OP_DIV, OP_MUL: plan_depth--;
      default: ;
    endcase
  endfunction

  function automatic int next_level();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return STACK_DEPTH;
    if (r < 4) return $urandom_range(9, 40);
    return $urandom_range(0, 8);
  endfunction

  // ------------------------------------------------------------------ sender

  assign idle_ok = idle_on && (total_items - n_accepted >= TAIL_ITEMS);

  always @(posedge clk) begin
    if (rst) begin
      window_left <= 0;
      idle_on     <= 1'b0;
    end else if (window_left == 0) begin
      window_left <= $urandom_range(30, 200);
      idle_on     <= $urandom_range(0, 2) != 0;
    end else begin
      window_left <= window_left - 1;
    end
  end

  always @(posedge clk) begin
    instr_t it;
    if (rst) begin
      in_valid   <= 1'b0;
      mode       <= OP_NOP;
      push_value <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        execute_instr(opcode_t'(mode), word_t'(push_value));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (idle_ok && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 14);
        end else if (pending_instrs.size() != 0) begin
          it = pending_instrs.pop_front();
          in_valid   <= 1'b1;
          mode       <= it.op;
          push_value <= it.arg;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- receiver

  // one long hold-off so the output register fills and the input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    print_result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%h data_valid=%b last=%b",
                   $time, status, data, data_valid, last);
          n_errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            n_errors++;
          end
          if (data !== exp_r.data) begin
            $display("%0t: data expected %h actual %h", $time, exp_r.data, data);
            n_errors++;
          end
          if (data_valid !== exp_r.data_valid) begin
            $display("%0t: data_valid expected %b actual %b", $time, exp_r.data_valid,
                     data_valid);
            n_errors++;
          end
          if (last !== exp_r.last) begin
            $display("%0t: last expected %b actual %b", $time, exp_r.last, last);
            n_errors++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else if (idle_ok && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        recv_gap  <= $urandom_range(0, 14);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------- stimulus

  initial begin
    int      level;
    int      planned;
    opcode_t op;

    // directed: wrap cases, truncating division, spare opcodes, empty print
    queue_instr(OP_PRINTALL, WORD_MAX);
    queue_instr(OP_NOP, WORD_MIN);
    queue_instr(OP_PUSH, WORD_MAX);
    queue_instr(OP_PUSH, WORD_ONE);
    queue_instr(OP_ADD, '0);
    queue_instr(OP_PRINTTOP, '0);
    queue_instr(OP_PUSH, WORD_MINUS_ONE);
    queue_instr(OP_DIV, '0);
    queue_instr(OP_PRINTTOP, '0);
    queue_instr(OP_PUSH, WORD_MIN);
    queue_instr(OP_MUL, '0);
    queue_instr(OP_PUSH, 32'd7);
    queue_instr(OP_PUSH, word_t'(-2));
    queue_instr(OP_DIV, '0);
    queue_instr(OP_PUSH, word_t'(-7));
    queue_instr(OP_PUSH, 32'd2);
    queue_instr(OP_DIV, '0);
    queue_instr(OP_SWAP, '0);
    queue_instr(OP_PRINTALL, '0);
    queue_instr(OP_POP, '0);
    queue_instr(OP_FIRST_SPARE, WORD_MAX);
    queue_instr(OP_LAST_SPARE, WORD_MIN);
    queue_instr(OP_PRINTALL, '0);

    // random: walk toward a target depth, print the whole stack on arrival;
    // the first target is a full stack
    level   = STACK_DEPTH;
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      op = opcode_t'($urandom_range(0, OP_LAST_SPARE));
      if (plan_depth < level && $urandom_range(0, 1) == 1) op = OP_PUSH;
      else if (plan_depth > level && $urandom_range(0, 1) == 1) op = OP_POP;
      case (op)
        OP_PUSH: if (plan_depth == STACK_DEPTH) op = OP_POP;
        OP_PRINTTOP, OP_POP: if (plan_depth == 0) op = OP_PUSH;
        OP_SWAP, OP_ADD, OP_MUL: if (plan_depth < 2) op = OP_PUSH;
        OP_DIV: begin
          if (plan_depth == 0) op = OP_PUSH;
          else if (plan_depth == STACK_DEPTH) op = OP_POP;
        end
        default: ;
      endcase
      if (op == OP_DIV) begin
        // fresh nonzero divisor keeps the stream error free
        queue_instr(OP_PUSH, nonzero_word());
        queue_instr(OP_DIV, rand_word());
        planned += 2;
      end else begin
        queue_instr(op, rand_word());
        planned++;
      end
      if (plan_depth == level) begin
        queue_instr(OP_PRINTALL, rand_word());
        planned++;
        level = next_level();
      end
    end

    // one error to end with, then the sticky halt
    case ($urandom_range(0, 3))
      0: begin
        while (plan_depth > 0) queue_instr(OP_POP, rand_word());
        queue_instr($urandom_range(0, 1) ? OP_POP : OP_PRINTTOP, rand_word());
      end
      1: begin
        while (plan_depth > 1) queue_instr(OP_POP, rand_word());
        if (plan_depth == 0 && $urandom_range(0, 1) == 1) queue_instr(OP_PUSH, rand_word());
        case ($urandom_range(0, 3))
          0: queue_instr(OP_SWAP, rand_word());
          1: queue_instr(OP_ADD, rand_word());
          2: queue_instr(OP_DIV, rand_word());
          default: queue_instr(OP_MUL, rand_word());
        endcase
      end
      2: begin
        if (plan_depth == 0) queue_instr(OP_PUSH, rand_word());
        if (plan_depth == STACK_DEPTH) queue_instr(OP_POP, rand_word());
        queue_instr(OP_PUSH, '0);
        queue_instr(OP_DIV, rand_word());
      end
      default: begin
        while (plan_depth < STACK_DEPTH) queue_instr(OP_PUSH, rand_word());
        queue_instr(OP_PUSH, rand_word());
      end
    endcase
    queue_instr(OP_PRINTALL, rand_word());
    for (int i = 0; i < 4; i++) queue_instr(opcode_t'($urandom_range(0, OP_LAST_SPARE)),
                                            rand_word());
    total_items = pending_instrs.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("%0t: timeout", $time);
    $display("FAILURE");
    $finish;
  end

endmodule
